@@ sv/kfsi_pkg.sv @@
// Shared constants and types for the keyframe size interpolator.
`default_nettype none

package kfsi_pkg;

  localparam int unsigned MaxStepsDef = 8;
  localparam int unsigned FracBitsDef = 16;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = $clog2(NumRegs);
  localparam int unsigned CfgIdxW  = RegIdxW + 1;
  localparam int unsigned StepW    = 51;
  localparam int unsigned PctW     = 17;
  localparam int unsigned SizeW    = 16;

  // Step word layout, MSB first: y, x, in use, has size, percent.
  typedef struct packed {
    logic [SizeW-1:0] y;
    logic [SizeW-1:0] x;
    logic             in_use;
    logic             has_size;
    logic [PctW-1:0]  pct;
  } step_t;

  // Blend operands carried alongside the divider.
  typedef struct packed {
    logic [SizeW-1:0]        ax;
    logic [SizeW-1:0]        ay;
    logic signed [SizeW:0]   dx;
    logic signed [SizeW:0]   dy;
    logic                    written;
  } blend_ctx_t;

endpackage

`default_nettype wire

@@ sv/keyframe_size_interpolator_unit.sv @@
// Keyframe size interpolator: step search, pipelined divider and blend.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | start_i, busy_o, life_fraction_i,         | in
//          | cur_width_i, cur_height_i                 |
//  result  | done_o, new_width_o, new_height_o,        | out
//          | size_written_o                            |
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in
//          | cfg_data_i                                |
//
// One request per cycle; each result passes through request capture, step search,
// operand setup, the restoring divider with one quotient bit per stage, the
// multiply and the output register.
// busy_o stays low: the receiver cannot stall, so the pipeline always moves.
// Reset clears the step registers and all stage valid bits.
// Step registers should be written only while no request is in flight; the block itself does not enforce this.
`default_nettype none

module keyframe_size_interpolator_unit
  import kfsi_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MaxStepsDef,
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [PctW-1:0]    life_fraction_i,
  input  wire logic [SizeW-1:0]   cur_width_i,
  input  wire logic [SizeW-1:0]   cur_height_i,
  output logic                    done_o,
  output logic [SizeW-1:0]        new_width_o,
  output logic [SizeW-1:0]        new_height_o,
  output logic                    size_written_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [StepW-1:0]   cfg_data_i
);

  localparam int unsigned TW   = FRAC_BITS + 1;   // blend factor, up to 1.0
  localparam int unsigned DivN = FRAC_BITS + 1;   // divider stages
  localparam int unsigned PrW  = FRAC_BITS + SizeW + 3;
  localparam int unsigned Lat  = FRAC_BITS + 6;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------- step registers ----------------
  step_t step_q [NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) step_q[i] <= '0;
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumRegs))) begin
      step_q[cfg_index_i[RegIdxW-1:0]] <= step_t'(cfg_data_i);
    end
  end

  // ---------------- stage 1: capture request ----------------
  logic             s1_v_q;
  logic [PctW-1:0]  s1_p_q;
  logic [SizeW-1:0] s1_cw_q, s1_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    s1_p_q  <= life_fraction_i;
    s1_cw_q <= cur_width_i;
    s1_ch_q <= cur_height_i;
  end

  // ---------------- stage 2: step search ----------------
  step_t src_d, tgt_d;
  logic  found_d;

  always_comb begin
    src_d   = '0;   // implicit first step: percent 0, no size
    tgt_d   = '0;
    found_d = 1'b0;
    for (int i = 0; i < MAX_STEPS; i++) begin
      if (!found_d && step_q[i].in_use) begin
        if (step_q[i].pct >= s1_p_q) begin
          tgt_d   = step_q[i];
          found_d = 1'b1;
        end else begin
          src_d = step_q[i];
        end
      end
    end
  end

  logic             s2_v_q, s2_apply_q;
  step_t            s2_src_q, s2_tgt_q;
  logic [PctW-1:0]  s2_p_q;
  logic [SizeW-1:0] s2_cw_q, s2_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else         s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    s2_apply_q <= found_d && tgt_d.has_size;
    s2_src_q   <= src_d;
    s2_tgt_q   <= tgt_d;
    s2_p_q     <= s1_p_q;
    s2_cw_q    <= s1_cw_q;
    s2_ch_q    <= s1_ch_q;
  end

  // ---------------- stage 3: divider operands and deltas ----------------
  // Unchanged size: a = b = current size, so the blend returns a whatever t is.
  // Coincident steps, no target or a target without size: num = den = 1 gives t = 1.0.
  blend_ctx_t      ctx_d;
  logic [SizeW-1:0] bx_d, by_d;
  logic [PctW-1:0] num_d, den_d;

  always_comb begin
    ctx_d.ax      = s2_cw_q;
    ctx_d.ay      = s2_ch_q;
    bx_d          = s2_cw_q;
    by_d          = s2_ch_q;
    ctx_d.written = s2_apply_q;
    if (s2_apply_q) begin
      if (s2_src_q.has_size) begin
        ctx_d.ax = s2_src_q.x;
        ctx_d.ay = s2_src_q.y;
      end
      bx_d = s2_tgt_q.x;
      by_d = s2_tgt_q.y;
    end
    ctx_d.dx = $signed({1'b0, bx_d}) - $signed({1'b0, ctx_d.ax});
    ctx_d.dy = $signed({1'b0, by_d}) - $signed({1'b0, ctx_d.ay});

    if (!s2_apply_q || (s2_tgt_q.pct <= s2_src_q.pct)) begin
      num_d = PctW'(1);
      den_d = PctW'(1);
    end else begin
      num_d = (s2_p_q > s2_src_q.pct) ? (s2_p_q - s2_src_q.pct) : '0;
      den_d = s2_tgt_q.pct - s2_src_q.pct;
    end
  end

  logic            s3_v_q;
  blend_ctx_t      s3_ctx_q;
  logic [PctW-1:0] s3_num_q, s3_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else         s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    s3_ctx_q <= ctx_d;
    s3_num_q <= num_d;
    s3_den_q <= den_d;
  end

  // ---------------- divider: one quotient bit per stage ----------------
  // num <= den, so stage 0 yields the integer bit and the rest the fraction.
  logic [DivN-1:0] dv_v_q;
  logic [PctW-1:0] rem_q [DivN];
  logic [PctW-1:0] dden_q [DivN];
  logic [TW-1:0]   quo_q [DivN];
  blend_ctx_t      dctx_q [DivN];

  for (genvar k = 0; k < DivN; k++) begin : g_div
    logic [PctW:0]   r2_d;
    logic [PctW-1:0] den_in_d, rem_d;
    logic [TW-1:0]   quo_in_d, quo_d;
    logic            v_in_d, ge_d;
    blend_ctx_t      ctx_in_d;

    if (k == 0) begin : g_first
      assign r2_d     = {1'b0, s3_num_q};
      assign den_in_d = s3_den_q;
      assign quo_in_d = '0;
      assign v_in_d   = s3_v_q;
      assign ctx_in_d = s3_ctx_q;
    end else begin : g_next
      assign r2_d     = {rem_q[k-1], 1'b0};
      assign den_in_d = dden_q[k-1];
      assign quo_in_d = quo_q[k-1];
      assign v_in_d   = dv_v_q[k-1];
      assign ctx_in_d = dctx_q[k-1];
    end

    always_comb begin
      ge_d  = r2_d >= {1'b0, den_in_d};
      rem_d = ge_d ? PctW'(r2_d - {1'b0, den_in_d}) : r2_d[PctW-1:0];
      quo_d = {quo_in_d[TW-2:0], ge_d};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k] <= 1'b0;
      else         dv_v_q[k] <= v_in_d;
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      dden_q[k] <= den_in_d;
      quo_q[k]  <= quo_d;
      dctx_q[k] <= ctx_in_d;
    end
  end

  // ---------------- multiply: delta * t ----------------
  logic                  m_v_q, m_wr_q;
  logic [SizeW-1:0]      m_ax_q, m_ay_q;
  logic signed [PrW-1:0] m_px_q, m_py_q;
  logic signed [TW:0]    t_s;

  assign t_s = $signed({1'b0, quo_q[DivN-1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else         m_v_q <= dv_v_q[DivN-1];
  end

  always_ff @(posedge clk_i) begin
    m_px_q <= PrW'(dctx_q[DivN-1].dx) * PrW'(t_s);
    m_py_q <= PrW'(dctx_q[DivN-1].dy) * PrW'(t_s);
    m_ax_q <= dctx_q[DivN-1].ax;
    m_ay_q <= dctx_q[DivN-1].ay;
    m_wr_q <= dctx_q[DivN-1].written;
  end

  // ---------------- round and output ----------------
  // a*(1-t) + b*t == a*1 + (b-a)*t; round half up.
  localparam logic [PrW-1:0] Half = PrW'(1) << (FRAC_BITS - 1);
  logic [PrW-1:0] sum_x_d, sum_y_d;

  always_comb begin
    sum_x_d = {3'b000, m_ax_q, {FRAC_BITS{1'b0}}} + m_px_q + Half;
    sum_y_d = {3'b000, m_ay_q, {FRAC_BITS{1'b0}}} + m_py_q + Half;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= m_v_q;
  end

  always_ff @(posedge clk_i) begin
    new_width_o    <= sum_x_d[FRAC_BITS+SizeW-1:FRAC_BITS];
    new_height_o   <= sum_y_d[FRAC_BITS+SizeW-1:FRAC_BITS];
    size_written_o <= m_wr_q;
  end

`ifndef ASSERT_OFF
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat done_o)
    else $error("request did not produce a result on time");

  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result without a matching request");

  a_unchanged_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !size_written_o) |->
      (new_width_o == $past(cur_width_i, Lat)) &&
      (new_height_o == $past(cur_height_i, Lat)))
    else $error("size changed although no step was applied");

  a_t_max_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[DivN-1] |-> (quo_q[DivN-1] <= (TW'(1) << FRAC_BITS)))
    else $error("blend factor above one");
`endif

endmodule

`default_nettype wire
